### sv/csor_pkg.sv
// ============================================================================
// csor_pkg
// Shared types, constants and window arithmetic for the counting sorter.
// ============================================================================
package csor_pkg;

    localparam int VAL_W     = 16;
    localparam int BINS      = 256;
    localparam int BIN_W     = $clog2(BINS);
    localparam int MAX_ITEMS = 64;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    // Wide enough for range_low + BINS - 1 without wrapping
    localparam int EXT_W     = VAL_W + 2;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);

    // Register select on paddr[2]
    localparam logic REG_RANGE_LOW  = 1'b0;
    localparam logic REG_RANGE_HIGH = 1'b1;

    localparam logic signed [VAL_W-1:0] RANGE_LOW_RST  = 16'sd0;
    localparam logic signed [VAL_W-1:0] RANGE_HIGH_RST = 16'sd255;

    // One classified item handed from the front to the back
    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic             counted;
        logic             last;
        logic             ovf;
        logic [CNT_W-1:0] total;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_INC,
        BK_WALK_RD,
        BK_WALK_CHK,
        BK_EMIT
    } back_state_t;

    // Effective upper bound: min(range_high, lo + BINS - 1), never below lo
    function automatic logic signed [EXT_W-1:0] window_top(
        input logic signed [VAL_W-1:0] lo,
        input logic signed [VAL_W-1:0] hi
    );
        logic signed [EXT_W-1:0] lo_x;
        logic signed [EXT_W-1:0] cap_x;
        logic signed [EXT_W-1:0] top_x;
        lo_x  = EXT_W'(lo);
        cap_x = lo_x + EXT_W'(BINS - 1);
        top_x = EXT_W'(hi);
        if (top_x > cap_x)
        begin
            top_x = cap_x;
        end
        if (top_x < lo_x)
        begin
            top_x = lo_x;
        end
        return top_x;
    endfunction

endpackage

### sv/counting_sort_offset_range_top.sv
// Flow: the front classifies a value item combinationally and pushes it to the queue;
// the back reads its histogram bin, writes it back incremented, and pops the next
// item only after that write. Last item: the walk skips empty bins on their valid
// flags up to the highest occupied bin, reads each occupied bin, emits its values.
// Reset: histogram bins read as zero at once through per-bin valid flags (no clearing
// pass); range_low = 0, range_high = 255.
// ============================================================================
// counting_sort_offset_range_top
// Counting sort over a configurable value window with APB-style registers.
// ============================================================================
module counting_sort_offset_range_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [csor_pkg::VAL_W-1:0] in_value,
    input  logic                              in_last,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [csor_pkg::VAL_W-1:0] out_value,
    output logic                              out_last,
    output logic                              overflowed
);
    import csor_pkg::*;

    logic signed [VAL_W-1:0] range_low_reg;
    logic signed [VAL_W-1:0] range_high_reg;
    logic                    cfg_wr;
    logic                    q_push;
    logic                    q_pop;
    logic                    q_full;
    logic                    q_empty;
    cmd_t                    q_in;
    cmd_t                    q_out;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= RANGE_LOW_RST;
            range_high_reg <= RANGE_HIGH_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_RANGE_LOW:  range_low_reg  <= pwdata[VAL_W-1:0];
                REG_RANGE_HIGH: range_high_reg <= pwdata[VAL_W-1:0];
                default:        range_low_reg  <= range_low_reg;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            case (paddr[2])
                REG_RANGE_LOW:  prdata = {16'h0000, range_low_reg};
                REG_RANGE_HIGH: prdata = {16'h0000, range_high_reg};
                default:        prdata = '0;
            endcase
        end
    end

    csor_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_value   (in_value),
        .in_last    (in_last),
        .in_stall   (in_stall),
        .range_low  (range_low_reg),
        .range_high (range_high_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_in)
    );

    csor_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    csor_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_out),
        .q_pop      (q_pop),
        .range_low  (range_low_reg),
        .range_high (range_high_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_value  (out_value),
        .out_last   (out_last),
        .overflowed (overflowed)
    );

`ifndef SYNTHESIS
    a_queue_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    a_queue_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command popped from an empty queue");

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_full && !q_push)
        else $error("input stalled while the queue has room");
`endif

endmodule

### sv/csor_front.sv
// ============================================================================
// csor_front
// Accepts input items, clamps them into the window, picks the bin and keeps
// the per-set item count and overflow flag.
// ============================================================================
module csor_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic signed [csor_pkg::VAL_W-1:0]    in_value,
    input  logic                                 in_last,
    output logic                                 in_stall,
    input  logic signed [csor_pkg::VAL_W-1:0]    range_low,
    input  logic signed [csor_pkg::VAL_W-1:0]    range_high,
    input  logic                                 q_full,
    output logic                                 q_push,
    output csor_pkg::cmd_t                       q_cmd
);
    import csor_pkg::*;

    logic [CNT_W-1:0]        item_count_reg;
    logic [CNT_W-1:0]        item_count_next;
    logic                    ovf_reg;
    logic                    ovf_next;
    logic signed [EXT_W-1:0] lo_x;
    logic signed [EXT_W-1:0] top_x;
    logic signed [EXT_W-1:0] v_x;
    logic signed [EXT_W-1:0] diff_x;
    logic                    counting;

    // Clamp the value into the window and form the bin
    always_comb
    begin
        lo_x  = EXT_W'(range_low);
        top_x = window_top(range_low, range_high);
        v_x   = EXT_W'(in_value);
        if (v_x < lo_x)
        begin
            v_x = lo_x;
        end
        if (v_x > top_x)
        begin
            v_x = top_x;
        end
        diff_x = v_x - lo_x;
    end

    assign counting = item_count_reg < CNT_W'(MAX_ITEMS);

    // Build the command for the back
    always_comb
    begin
        q_cmd.bin     = diff_x[BIN_W-1:0];
        q_cmd.counted = counting;
        q_cmd.last    = in_last;
        q_cmd.ovf     = ovf_reg | ~counting;
        q_cmd.total   = counting ? (item_count_reg + CNT_W'(1)) : item_count_reg;
    end

    assign in_stall = q_full;
    assign q_push   = in_valid & ~q_full;

    // Advance the set counters, restart them after the last item
    always_comb
    begin
        item_count_next = item_count_reg;
        ovf_next        = ovf_reg;
        if (q_push)
        begin
            if (in_last)
            begin
                item_count_next = '0;
                ovf_next        = 1'b0;
            end
            else
            begin
                item_count_next = q_cmd.total;
                ovf_next        = q_cmd.ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            item_count_reg <= item_count_next;
            ovf_reg        <= ovf_next;
        end
    end

endmodule

### sv/csor_queue.sv
// ============================================================================
// csor_queue
// Short command FIFO that decouples the front from the back.
// ============================================================================
module csor_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  csor_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output csor_pkg::cmd_t pop_data,
    output logic           empty
);
    import csor_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full     = count_reg == (QPTR_W + 1)'(QDEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = slot_reg[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/csor_back.sv
// ============================================================================
// csor_back
// Updates the histogram memory and, on the last item of a set, walks the
// bins in ascending order and emits the sorted values.
// ============================================================================
module csor_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    input  csor_pkg::cmd_t                    q_data,
    output logic                              q_pop,
    input  logic signed [csor_pkg::VAL_W-1:0] range_low,
    input  logic signed [csor_pkg::VAL_W-1:0] range_high,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [csor_pkg::VAL_W-1:0] out_value,
    output logic                              out_last,
    output logic                              overflowed
);
    import csor_pkg::*;

    back_state_t             state_reg;
    back_state_t             state_next;
    cmd_t                    cmd_reg;
    cmd_t                    cmd_next;
    logic [BIN_W-1:0]        bin_idx_reg;
    logic [BIN_W-1:0]        bin_idx_next;
    logic [CNT_W-1:0]        bin_left_reg;
    logic [CNT_W-1:0]        bin_left_next;
    logic [CNT_W-1:0]        total_left_reg;
    logic [CNT_W-1:0]        total_left_next;
    logic [BINS-1:0]         valid_reg;
    logic [CNT_W-1:0]        mem [BINS];
    logic [CNT_W-1:0]        rdata_reg;
    logic                    rvalid_reg;
    logic [BIN_W-1:0]        raddr;
    logic                    mem_we;
    logic [CNT_W-1:0]        wdata;
    logic                    set_valid;
    logic                    clear_all;
    logic                    out_free;
    logic                    out_load;
    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic                    out_last_reg;
    logic                    overflowed_reg;
    logic signed [EXT_W-1:0] top_x;
    logic signed [EXT_W-1:0] val_x;
    logic                    emit_last;

    assign out_free  = ~out_valid_reg | ~out_stall;
    assign emit_last = total_left_reg == CNT_W'(1);

    // Value of the current bin, saturated to the effective upper bound
    always_comb
    begin
        top_x = window_top(range_low, range_high);
        val_x = EXT_W'(range_low) + signed'(EXT_W'(bin_idx_reg));
        if (val_x > top_x)
        begin
            val_x = top_x;
        end
    end

    // Sequencer: increment on load, walk and emit on the last item
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        bin_idx_next    = bin_idx_reg;
        bin_left_next   = bin_left_reg;
        total_left_next = total_left_reg;
        q_pop           = 1'b0;
        raddr           = bin_idx_reg;
        mem_we          = 1'b0;
        wdata           = (rvalid_reg ? rdata_reg : '0) + CNT_W'(1);
        set_valid       = 1'b0;
        clear_all       = 1'b0;
        out_load        = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                raddr = q_data.bin;
                if (!q_empty)
                begin
                    q_pop           = 1'b1;
                    cmd_next        = q_data;
                    total_left_next = q_data.total;
                    bin_idx_next    = '0;
                    if (q_data.counted)
                    begin
                        state_next = BK_INC;
                    end
                    else if (q_data.last)
                    begin
                        state_next = BK_WALK_RD;
                    end
                end
            end
            BK_INC:
            begin
                mem_we     = 1'b1;
                set_valid  = 1'b1;
                state_next = cmd_reg.last ? BK_WALK_RD : BK_IDLE;
            end
            BK_WALK_RD:
            begin
                // Skip empty bins on their valid flags, without waiting for a memory read
                if (valid_reg[bin_idx_reg])
                begin
                    state_next = BK_WALK_CHK;
                end
                else
                begin
                    bin_idx_next = bin_idx_reg + BIN_W'(1);
                end
            end
            BK_WALK_CHK:
            begin
                bin_left_next = rdata_reg;
                state_next    = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    total_left_next = total_left_reg - CNT_W'(1);
                    bin_left_next   = bin_left_reg - CNT_W'(1);
                    if (emit_last)
                    begin
                        clear_all  = 1'b1;
                        state_next = BK_IDLE;
                    end
                    else if (bin_left_reg == CNT_W'(1))
                    begin
                        bin_idx_next = bin_idx_reg + BIN_W'(1);
                        state_next   = BK_WALK_RD;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clear_all)
            begin
                valid_reg <= '0;
            end
            else if (set_valid)
            begin
                valid_reg[cmd_reg.bin] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        bin_idx_reg    <= bin_idx_next;
        bin_left_reg   <= bin_left_next;
        total_left_reg <= total_left_next;
        if (out_load)
        begin
            out_value_reg  <= val_x[VAL_W-1:0];
            out_last_reg   <= emit_last;
            overflowed_reg <= cmd_reg.ovf;
        end
    end

    // Histogram memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cmd_reg.bin] <= wdata;
        end
        rdata_reg  <= mem[raddr];
        rvalid_reg <= valid_reg[raddr];
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_last   = out_last_reg;
    assign overflowed = overflowed_reg;

endmodule
